/* rtl/assert_macros.svh */
// assertion macros for the run-length line table rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define RLLT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define RLLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RLLT_ASSERT(lbl, clk, rstn, prop, msg)
`define RLLT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

/* rtl/rllt_pkg.sv */
// shared types, codes and defaults of the run-length line table
// no dependencies
package rllt_pkg;

  localparam int CODE_W     = 8;
  localparam int SRC_LINE_W = 16;
  localparam int OFFSET_W   = 12;

  localparam int BYTE_DEPTH_DEF = 4096;
  localparam int RUN_DEPTH_DEF  = 1024;
  localparam int LINE_BITS_DEF  = 16;

  typedef enum logic [0:0] {
    ACT_APPEND,
    ACT_LOOKUP
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE,
    STAT_FULL,
    STAT_UNCOVERED
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_e;

  typedef struct packed {
    action_e               action;
    logic [CODE_W-1:0]     code_byte;
    logic [SRC_LINE_W-1:0] source_line;
    logic [OFFSET_W-1:0]   byte_offset;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [SRC_LINE_W-1:0] found_line;
    logic [OFFSET_W-1:0]   byte_position;
  } res_t;

  typedef struct packed {
    logic append;
    logic lkp_init;
    logic rd;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic uncovered;
    logic hit;
  } stat_t;

endpackage

/* rtl/rllt_ctrl.sv */
// sequencing state machine of the run-length line table
// depends on rllt_pkg
module rllt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  rllt_pkg::action_e action_i,
  input  rllt_pkg::stat_t  stat_i,
  output rllt_pkg::cmd_t   cmd_o,
  output logic             busy_o,
  output logic             res_valid_o
);

  rllt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rllt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      rllt_pkg::ST_IDLE: begin
        if (start_i) begin
          if (action_i == rllt_pkg::ACT_APPEND) begin
            cmd_o.append = 1'b1;
            state_d      = rllt_pkg::ST_DONE;
          end else begin
            cmd_o.lkp_init = 1'b1;
            state_d        = stat_i.uncovered ? rllt_pkg::ST_DONE : rllt_pkg::ST_READ;
          end
        end
      end
      rllt_pkg::ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = rllt_pkg::ST_CHECK;
      end
      rllt_pkg::ST_CHECK: begin
        cmd_o.step = 1'b1;
        state_d    = stat_i.hit ? rllt_pkg::ST_DONE : rllt_pkg::ST_READ;
      end
      rllt_pkg::ST_DONE: begin
        state_d = rllt_pkg::ST_IDLE;
      end
      default: begin
        state_d = rllt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o      = (state_q != rllt_pkg::ST_IDLE);
  assign res_valid_o = (state_q == rllt_pkg::ST_DONE);

endmodule

/* rtl/rllt_dp.sv */
// datapath of the run-length line table: byte store, run memories, counters
// and the run walk; depends on rllt_pkg
module rllt_dp #(
  parameter int BYTE_DEPTH = rllt_pkg::BYTE_DEPTH_DEF,
  parameter int RUN_DEPTH  = rllt_pkg::RUN_DEPTH_DEF,
  parameter int LINE_BITS  = rllt_pkg::LINE_BITS_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rllt_pkg::req_t  req_i,
  input  rllt_pkg::cmd_t  cmd_i,
  output rllt_pkg::stat_t stat_o,
  output rllt_pkg::res_t  res_o
);

  localparam int BIDX_W = $clog2(BYTE_DEPTH);
  localparam int CNT_W  = $clog2(BYTE_DEPTH + 1);
  localparam int RIDX_W = $clog2(RUN_DEPTH);
  localparam int RCNT_W = $clog2(RUN_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > rllt_pkg::OFFSET_W) ? CNT_W : rllt_pkg::OFFSET_W;
  localparam int LEXT_W = (LINE_BITS > rllt_pkg::SRC_LINE_W) ? LINE_BITS
                                                              : rllt_pkg::SRC_LINE_W;

  logic [rllt_pkg::CODE_W-1:0] byte_mem [BYTE_DEPTH];
  logic [LINE_BITS-1:0]        line_mem [RUN_DEPTH];
  logic [CNT_W-1:0]            len_mem  [RUN_DEPTH];

  logic [CNT_W-1:0]     bytes_held_q;
  logic [RCNT_W-1:0]    runs_held_q;
  logic [LINE_BITS-1:0] last_line_q;
  logic [CNT_W-1:0]     last_len_q;
  logic [RIDX_W-1:0]    idx_q;
  logic [CNT_W-1:0]     sum_q;
  logic [rllt_pkg::OFFSET_W-1:0] offset_q;
  logic [CNT_W-1:0]     rd_len_q;
  logic [LINE_BITS-1:0] rd_line_q;
  rllt_pkg::res_t       res_q;

  logic [LEXT_W-1:0]    line_ext;
  logic [LINE_BITS-1:0] line_m;
  logic                 extend;
  logic                 reject;
  logic                 do_write;
  logic [RCNT_W-1:0]    runs_last;
  logic [RIDX_W-1:0]    len_waddr;
  logic [CNT_W-1:0]     len_wdata;
  logic [CMP_W-1:0]     pos_ext;
  logic [CMP_W-1:0]     offset_ext;
  logic [CNT_W-1:0]     sum_next;
  logic [LEXT_W-1:0]    found_ext;

  assign line_ext  = LEXT_W'(req_i.source_line);
  assign line_m    = line_ext[LINE_BITS-1:0];
  assign extend    = (runs_held_q != '0) && (last_line_q == line_m);
  assign reject    = (bytes_held_q == CNT_W'(BYTE_DEPTH)) ||
                     (!extend && (runs_held_q == RCNT_W'(RUN_DEPTH)));
  assign do_write  = cmd_i.append && !reject;
  assign runs_last = runs_held_q - RCNT_W'(1);
  assign len_waddr = extend ? runs_last[RIDX_W-1:0] : runs_held_q[RIDX_W-1:0];
  assign len_wdata = extend ? (last_len_q + CNT_W'(1)) : CNT_W'(1);
  assign pos_ext   = CMP_W'(bytes_held_q);
  assign offset_ext = CMP_W'(req_i.byte_offset);
  assign sum_next  = sum_q + rd_len_q;
  assign found_ext = LEXT_W'(rd_line_q);

  // all runs together cover exactly the bytes held
  assign stat_o.uncovered = (offset_ext >= pos_ext);
  assign stat_o.hit       = (CMP_W'(offset_q) < CMP_W'(sum_next));

  // store writes and registered run reads
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      byte_mem[bytes_held_q[BIDX_W-1:0]] <= req_i.code_byte;
      len_mem[len_waddr] <= len_wdata;
      if (!extend) begin
        line_mem[runs_held_q[RIDX_W-1:0]] <= line_m;
      end
    end
    if (cmd_i.rd) begin
      rd_len_q  <= len_mem[idx_q];
      rd_line_q <= line_mem[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_held_q <= '0;
      runs_held_q  <= '0;
    end else if (do_write) begin
      bytes_held_q <= bytes_held_q + CNT_W'(1);
      if (!extend) begin
        runs_held_q <= runs_held_q + RCNT_W'(1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (do_write) begin
      last_len_q <= len_wdata;
      if (!extend) begin
        last_line_q <= line_m;
      end
    end
    if (cmd_i.lkp_init) begin
      idx_q    <= '0;
      sum_q    <= '0;
      offset_q <= req_i.byte_offset;
    end else if (cmd_i.step) begin
      sum_q <= sum_next;
      if (!stat_o.hit) begin
        idx_q <= idx_q + RIDX_W'(1);
      end
    end
    if (cmd_i.append) begin
      res_q.found_line <= '0;
      if (reject) begin
        res_q.status        <= rllt_pkg::STAT_FULL;
        res_q.byte_position <= '0;
      end else begin
        res_q.status        <= rllt_pkg::STAT_DONE;
        res_q.byte_position <= pos_ext[rllt_pkg::OFFSET_W-1:0];
      end
    end else if (cmd_i.lkp_init && stat_o.uncovered) begin
      res_q.status        <= rllt_pkg::STAT_UNCOVERED;
      res_q.found_line    <= '0;
      res_q.byte_position <= '0;
    end else if (cmd_i.step && stat_o.hit) begin
      res_q.status        <= rllt_pkg::STAT_DONE;
      res_q.found_line    <= found_ext[rllt_pkg::SRC_LINE_W-1:0];
      res_q.byte_position <= '0;
    end
  end

  assign res_o = res_q;

endmodule

/* rtl/run_length_line_table.sv */
// top level of the run-length line table: controller plus datapath
// depends on rllt_pkg, rllt_ctrl, rllt_dp and assert_macros.svh
//
// A command is taken at a clock edge where start is high and busy is low.
// Every command gives exactly one result, shown on res_o for a single cycle
// while res_valid_o is high; the receiver cannot stall, so it must take the
// result in that cycle. An append goes from the accept cycle to the result
// cycle, then the next command can be taken. A lookup walks the run table
// from the first run through the single read port of the run memories,
// whose read data is registered: each run is read in the read state and
// checked in the check state until the offset falls inside it; an offset
// that is not covered skips the walk. No clearing pass is needed after reset.
`include "assert_macros.svh"

module run_length_line_table #(
  parameter int BYTE_DEPTH = rllt_pkg::BYTE_DEPTH_DEF,
  parameter int RUN_DEPTH  = rllt_pkg::RUN_DEPTH_DEF,
  parameter int LINE_BITS  = rllt_pkg::LINE_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rllt_pkg::req_t req_i,
  output logic           res_valid_o,
  output rllt_pkg::res_t res_o
);

  // command and status between controller and datapath
  rllt_pkg::cmd_t  cmd;
  rllt_pkg::stat_t stat;

  // sequencer: accept, run walk, result strobe
  rllt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .action_i    (req_i.action),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .res_valid_o (res_valid_o)
  );

  // stores, counters and the walk accumulator
  rllt_dp #(
    .BYTE_DEPTH (BYTE_DEPTH),
    .RUN_DEPTH  (RUN_DEPTH),
    .LINE_BITS  (LINE_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .stat_o (stat),
    .res_o  (res_o)
  );

  // a transfer always makes the block busy in the next cycle
  `RLLT_ASSERT_NEXT(a_busy_after_xfer, clk_i, rst_ni, start && !busy, busy, "not busy after transfer")
  // an append answers in the very next cycle
  `RLLT_ASSERT_NEXT(a_append_latency, clk_i, rst_ni, start && !busy && (req_i.action == rllt_pkg::ACT_APPEND), res_valid_o, "append result late")
  // the result strobe lasts one cycle
  `RLLT_ASSERT_NEXT(a_strobe_single, clk_i, rst_ni, res_valid_o, !res_valid_o, "result strobe held")
  // a result only comes while a command is in flight
  `RLLT_ASSERT(a_strobe_busy, clk_i, rst_ni, !res_valid_o || busy, "result while idle")

endmodule

/* verif/tb_run_length_line_table.sv */
// testbench for run_length_line_table: directed, random and fill-to-capacity command streams
// depends on rllt_pkg and the run_length_line_table rtl; self-checking against its own table model
`timescale 1ns / 100ps

module tb_run_length_line_table;
  import rllt_pkg::*;

  localparam int BYTE_CAP     = BYTE_DEPTH_DEF;
  localparam int RUN_CAP      = RUN_DEPTH_DEF;
  localparam int ITEM_BUDGET  = 1850;
  // random mix leaves room for the run table fill and the closing part
  localparam int RANDOM_ITEMS = ITEM_BUDGET - RUN_CAP;
  localparam int GROW_ITEMS   = 300;
  // slowest single command is a lookup ending in the last run, plus a sender gap
  localparam int STALL_LIMIT  = 10 * (2 * RUN_CAP + 8);
  localparam int DRAIN_CYCLES = 64;

  logic clk_i;
  logic rst_ni;
  logic start;
  logic busy;
  req_t req_i;
  logic res_valid_o;
  res_t res_o;

  run_length_line_table #(
    .BYTE_DEPTH(BYTE_CAP),
    .RUN_DEPTH (RUN_CAP),
    .LINE_BITS (LINE_BITS_DEF)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  // 2 ns clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // commands waiting to be driven, answers waiting to come back
  req_t pending_cmds[$];
  res_t awaited_answers[$];
  int   pend_cnt     = 0;
  int   items_made   = 0;
  int   err_cnt      = 0;
  int   stall_cycles = 0;
  int   gap_left     = 0;
  logic gaps_on      = 1'b1;
  logic cmd_took     = 1'b0;

  // shadow of the line table: run lines, run lengths and fill counts
  logic [SRC_LINE_W-1:0] run_line [RUN_CAP];
  logic [12:0]           run_len  [RUN_CAP];
  int                    run_cnt  = 0;
  int                    byte_cnt = 0;

  // apply one command to the shadow table and return the answer it gives
  function automatic res_t apply_to_table(req_t rq);
    res_t ans;
    logic grows;
    int   walked;
    ans = '0;
    ans.status = STAT_DONE;
    if (rq.action == ACT_APPEND) begin
      // same line as the newest run extends it, anything else opens a run
      grows = (run_cnt != 0) && (run_line[run_cnt-1] == rq.source_line);
      if (byte_cnt >= BYTE_CAP || (!grows && run_cnt >= RUN_CAP)) begin
        ans.status = STAT_FULL;
      end else begin
        ans.byte_position = OFFSET_W'(byte_cnt);
        byte_cnt++;
        if (grows) begin
          run_len[run_cnt-1] = run_len[run_cnt-1] + 13'd1;
        end else begin
          run_line[run_cnt] = rq.source_line;
          run_len[run_cnt]  = 13'd1;
          run_cnt++;
        end
      end
    end else begin
      // walk the runs summing lengths until the offset falls inside one
      ans.status = STAT_UNCOVERED;
      walked = 0;
      for (int k = 0; k < run_cnt; k++) begin
        walked += run_len[k];
        if (rq.byte_offset < walked) begin
          ans.status     = STAT_DONE;
          ans.found_line = run_line[k];
          break;
        end
      end
    end
    return ans;
  endfunction

  task automatic report_mismatch(string what);
    err_cnt++;
    if (err_cnt <= 40) $display("%0t mismatch: %s", $time, what);
  endtask

  // unused fields always carry random values, the block must ignore them
  task automatic queue_append(logic [SRC_LINE_W-1:0] line, logic [CODE_W-1:0] code);
    req_t r;
    r.action      = ACT_APPEND;
    r.code_byte   = code;
    r.source_line = line;
    r.byte_offset = OFFSET_W'($urandom);
    pending_cmds.push_back(r);
    pend_cnt++;
    items_made++;
  endtask

  task automatic queue_lookup(int offset);
    req_t r;
    r.action      = ACT_LOOKUP;
    r.code_byte   = CODE_W'($urandom);
    r.source_line = SRC_LINE_W'($urandom);
    r.byte_offset = OFFSET_W'(offset);
    pending_cmds.push_back(r);
    pend_cnt++;
    items_made++;
  endtask

  // a line that cannot extend the newest run
  function automatic logic [SRC_LINE_W-1:0] fresh_line();
    logic [SRC_LINE_W-1:0] l;
    l = SRC_LINE_W'($urandom);
    if (run_cnt != 0 && l == run_line[run_cnt-1]) l = l ^ SRC_LINE_W'(1);
    return l;
  endfunction

  // driver: new command on the falling edge, held until its transfer
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !cmd_took) begin
      // transfer still pending, keep the command steady
    end else if (gap_left > 0) begin
      start <= 1'b0;
      gap_left--;
    end else if (pend_cnt == 0) begin
      start <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      // idle burst: start low now and for a random gap_left after
      start <= 1'b0;
      gap_left = $urandom_range(0, 2);
    end else begin
      start <= 1'b1;
      req_i <= pending_cmds[0];
    end
  end

  // monitor: check results first, then record the command transfer of this edge
  always @(posedge clk_i) begin : monitor
    res_t want;
    cmd_took = 1'b0;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (awaited_answers.size() == 0) begin
          report_mismatch("result with no command outstanding");
        end else begin
          want = awaited_answers.pop_front();
          if (res_o.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", res_o.status, want.status));
          if (res_o.found_line !== want.found_line)
            report_mismatch($sformatf("found_line got %0d want %0d",
                                      res_o.found_line, want.found_line));
          if (res_o.byte_position !== want.byte_position)
            report_mismatch($sformatf("byte_position got %0d want %0d",
                                      res_o.byte_position, want.byte_position));
        end
      end
      if (start && !busy) begin
        cmd_took = 1'b1;
        awaited_answers.push_back(apply_to_table(req_i));
        void'(pending_cmds.pop_front());
        pend_cnt--;
      end
    end
  end

  // watchdog: too long without any transfer on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || res_valid_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t no transfer for %0d cycles", $time, stall_cycles);
      $display("tb_run_length_line_table: FAIL");
      $finish;
    end
  end

  // stimulus: each chunk is built once the previous one is fully transferred,
  // so the generator can steer by the shadow table
  initial begin : stimulus
    int pick;
    int glen;
    int toggle_at;
    logic [SRC_LINE_W-1:0] line;
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, extreme lines, extend, reopen an old line, edges of coverage
    queue_lookup(0);
    queue_lookup(4095);
    queue_append(16'h0000, 8'h00);
    queue_append(16'h0000, 8'hFF);
    queue_append(16'hFFFF, 8'hA5);
    queue_append(16'hFFFF, 8'h5A);
    queue_append(16'h0000, 8'h3C);
    queue_append(16'h0001, 8'hC3);
    for (int k = 0; k <= 6; k++) queue_lookup(k);
    queue_lookup(4095);
    wait (pend_cnt == 0);

    // random mix: grouped appends with varied line reuse, occasional lookups
    toggle_at = items_made + 100;
    while (items_made < RANDOM_ITEMS) begin
      wait (pend_cnt == 0);
      if (items_made >= toggle_at) begin
        // stretches with and without sender gaps
        gaps_on   = ($urandom_range(0, 3) != 0);
        toggle_at = items_made + $urandom_range(60, 200);
      end
      if ($urandom_range(0, 99) < 12) begin
        pick = $urandom_range(0, 99);
        if (byte_cnt == 0 || pick >= 80) queue_lookup($urandom_range(0, 4095));
        else if (pick < 50) queue_lookup($urandom_range(0, byte_cnt - 1));
        else if (pick < 60) queue_lookup(byte_cnt - 1);
        else if (pick < 70) queue_lookup(byte_cnt);
        else queue_lookup(0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 15 && run_cnt != 0) line = run_line[run_cnt-1];
        else if (pick < 22) line = '0;
        else if (pick < 29) line = '1;
        else if (pick < 40 && run_cnt != 0) line = run_line[$urandom_range(0, run_cnt - 1)];
        else line = SRC_LINE_W'($urandom);
        glen = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 6) : 1;
        for (int k = 0; k < glen; k++) queue_append(line, CODE_W'($urandom));
      end
    end

    // last part, no sender gaps: fill the run table
    wait (pend_cnt == 0);
    gaps_on = 1'b0;
    while (run_cnt < RUN_CAP && byte_cnt < BYTE_CAP) begin
      queue_append(fresh_line(), CODE_W'($urandom));
      wait (pend_cnt == 0);
    end
    // run table full: new lines are refused, the deepest lookup walks every run
    for (int k = 0; k < 3; k++) queue_append(fresh_line(), CODE_W'($urandom));
    queue_lookup(byte_cnt - 1);
    queue_lookup(byte_cnt);
    wait (pend_cnt == 0);
    // the newest run can still grow while the run table is full
    for (int k = 0; k < GROW_ITEMS && byte_cnt < BYTE_CAP; k++) begin
      if (k % 64 == 0) queue_lookup($urandom_range(0, byte_cnt - 1));
      queue_append(run_line[run_cnt-1], CODE_W'($urandom));
      wait (pend_cnt == 0);
    end
    // newest line still grows, a new line is refused, coverage edges
    queue_append(run_line[run_cnt-1], CODE_W'($urandom));
    queue_append(fresh_line(), CODE_W'($urandom));
    queue_lookup(4095);
    queue_lookup(0);
    for (int k = 0; k < 4; k++) queue_lookup($urandom_range(0, 4095));
    wait (pend_cnt == 0);

    // let every answer come back, then watch a little longer for strays
    while (awaited_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tb_run_length_line_table: PASS");
    end else begin
      $display("tb_run_length_line_table: FAIL");
    end
    $finish;
  end

endmodule
